/* rtl/mss_pkg.sv */
// ----------------------------------------------------------------------------
// mss_pkg: shared types for the value set sorter
// Data word type and the per-cell control group of the insertion chain.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // insert the incoming value
    logic pop;   // shift the chain one place toward cell zero
  } cell_ctrl_t;

endpackage

/* rtl/mss_cell.sv */
// ----------------------------------------------------------------------------
// mss_cell: one slot of the insertion chain
// Holds one value; on insert it keeps, takes the new value or takes its left
// neighbor's value; on pop it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module mss_cell (
  input  logic               clk,
  input  logic               rst,
  input  mss_pkg::cell_ctrl_t ctrl,
  input  mss_pkg::data_t     new_value,
  input  mss_pkg::data_t     left_value,
  input  logic               left_valid,
  input  logic               left_lt,
  input  mss_pkg::data_t     right_value,
  input  logic               right_valid,
  output mss_pkg::data_t     value,
  output logic               valid,
  output logic               lt
);
  import mss_pkg::*;

  // new value goes at or before this slot
  assign lt = !valid || (new_value < value);

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= right_valid;
    end else if (ctrl.ins && lt) begin
      valid <= left_lt ? left_valid : 1'b1;
    end
  end

  // stored value
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      value <= right_value;
    end else if (ctrl.ins && lt) begin
      value <= left_lt ? left_value : new_value;
    end
  end

endmodule

/* rtl/merge_and_sort_value_set_top.sv */
// ----------------------------------------------------------------------------
// merge_and_sort_value_set_top: insertion sorter for a set of signed values
// Systolic chain of MAX_ITEMS cells kept in ascending order at all times.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (value, has_value, set_end, in_valid/in_ready): one beat per
//   element. While a set is being collected a beat is taken every cycle; the
//   new value is placed into the chain in the cycle it is accepted.
//   A beat with has_value low inserts nothing. Elements arriving when all
//   MAX_ITEMS cells are full are dropped and the overflow bit is raised for
//   the set.
//   A beat with set_end high starts the drain: the chain shifts toward cell
//   zero one place per cycle while the receiver is ready, and the output
//   channel (sorted_value, final_flag, overflow, out_valid/out_ready) gives
//   the held values in ascending order, final_flag on the last. An empty set
//   gives no beat. Drain: each result beat comes from the output register;
//   a set drains one beat per cycle while the receiver takes them. in_ready
//   is low from the set_end beat until the chain is empty, and stays low
//   while the receiver stalls. The drain is paced by the single output
//   register: when the receiver stalls the chain holds. Input and output are
//   otherwise separate.
//   Reset (rst, synchronous) empties the chain and clears the overflow bit.
// ----------------------------------------------------------------------------
module merge_and_sort_value_set_top #(
  parameter int MAX_ITEMS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  mss_pkg::data_t value,
  input  logic           has_value,
  input  logic           set_end,
  input  logic           in_valid,
  output logic           in_ready,
  output mss_pkg::data_t sorted_value,
  output logic           final_flag,
  output logic           overflow,
  output logic           out_valid,
  input  logic           out_ready
);
  import mss_pkg::*;

  data_t       cell_value [MAX_ITEMS];
  logic        cell_valid [MAX_ITEMS];
  logic        cell_lt    [MAX_ITEMS];
  cell_ctrl_t  ctrl;

  logic draining;
  logic ovf_seen;
  logic drain_ovf;
  logic in_fire;
  logic full;
  logic pop;

  // handshake and chain control
  assign in_ready = !draining;
  assign in_fire  = in_valid && in_ready;
  assign full     = cell_valid[MAX_ITEMS-1];
  assign pop      = draining && cell_valid[0] && (!out_valid || out_ready);

  assign ctrl = cell_ctrl_t'{ins: in_fire && has_value && !full, pop: pop};

  // chain of cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    data_t left_value;
    logic  left_valid;
    logic  left_lt;
    data_t right_value;
    logic  right_valid;

    if (i == 0) begin : g_first
      assign left_value = value;
      assign left_valid = 1'b1;
      assign left_lt    = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_lt    = cell_lt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign right_value = cell_value[i];
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    mss_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_value   (value),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .left_lt     (left_lt),
      .right_value (right_value),
      .right_valid (right_valid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .lt          (cell_lt[i])
    );
  end

  // drain mode and overflow tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      ovf_seen <= 1'b0;
    end else begin
      if (in_fire) begin
        if (set_end) begin
          draining <= 1'b1;
          ovf_seen <= 1'b0;
        end else if (has_value && full) begin
          ovf_seen <= 1'b1;
        end
      end else if (draining && (!cell_valid[0] || (pop && !cell_valid[1]))) begin
        draining <= 1'b0;
      end
    end
  end

  // overflow bit carried by the set being drained
  always_ff @(posedge clk) begin
    if (in_fire && set_end) begin
      drain_ovf <= ovf_seen || (has_value && full);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sorted_value <= cell_value[0];
      final_flag   <= !cell_valid[1];
      overflow     <= drain_ovf;
    end
  end

endmodule
